// ===== src/sqfp_pkg.sv =====
// Shared constants for the sine quadrant-fold polynomial block.
// Angle reduction constants in unsigned Q.32 and polynomial coefficients.
// No dependencies.
package sqfp_pkg;

    // Pipeline depth, input register through output register.
    localparam int NUM_STAGES = 14;

    // Angle reduction constants, unsigned Q.32 (exact for the single-precision PI).
    localparam logic [39:0] TWO_PI_Q32     = 40'd26986076160;
    localparam logic [34:0] HALF_PI_Q32    = 35'd6746519040;
    localparam logic [34:0] PI_Q32         = 35'd13493038080;
    localparam logic [34:0] THREE_HALF_PI_Q32 = 35'd20239557120;
    localparam logic [34:0] TWO_PI_Q32_N   = 35'd26986076160;

    // Taylor coefficients 1/6, 1/120, 1/5040, 1/362880 in Q.32, and one.
    localparam logic [29:0] ALPHA_Q32 = 30'd715827904;
    localparam logic [25:0] BETA_Q32  = 26'd35791396;
    localparam logic [19:0] GAMMA_Q32 = 20'd852176;
    localparam logic [13:0] DELTA_Q32 = 14'd11836;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

endpackage

// ===== src/sine_quadrant_fold_polynomial.sv =====
// Sine of a Q8.24 angle in radians, result in Q2.30 saturated to +/-1.0.
// Throughput: one beat per cycle when the output is not stalled; five restoring
// modulo-2*PI steps, a fold stage and one multiplier stage per polynomial term
// set the depth.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
// Depends on sqfp_pkg.
module sine_quadrant_fold_polynomial (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] sine_value
);

    localparam int NS = sqfp_pkg::NUM_STAGES;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] adv;

    // Stage data
    logic [39:0] red_reg [0:5];
    logic [39:0] red_next [1:5];
    logic        neg_reg [0:12];
    logic [30:0] x_reg   [6:11];
    logic [31:0] x2_reg  [7:10];
    logic [15:0] p1_reg;
    logic [21:0] p2_reg;
    logic [27:0] p3_reg;
    logic [31:0] p4_reg;
    logic [31:0] y_reg;
    logic [31:0] out_reg;

    logic [31:0] mag;
    logic [34:0] r;
    logic [34:0] xf;
    logic        fold_neg;
    logic [61:0] sq_prod;
    logic [45:0] prod1;
    logic [19:0] t1;
    logic [51:0] prod2;
    logic [25:0] t2;
    logic [57:0] prod3;
    logic [29:0] t3;
    logic [61:0] prod4;
    logic [32:0] t4;
    logic [63:0] prod5;
    logic [31:0] ysat;
    logic [31:0] out_next;

    // Each stage advances when it is empty or the next stage advances.
    always_comb begin
        adv[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Magnitude of the angle; the most negative code gives exactly 2^31.
    assign mag = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;

    // Restoring reduction modulo 2*PI, one multiple per stage (16x down to 1x).
    always_comb begin
        for (int k = 1; k <= 5; k++) begin
            if (red_reg[k-1] >= (sqfp_pkg::TWO_PI_Q32 << (5 - k))) begin
                red_next[k] = red_reg[k-1] - (sqfp_pkg::TWO_PI_Q32 << (5 - k));
            end else begin
                red_next[k] = red_reg[k-1];
            end
        end
    end

    // Fold into the first quadrant; boundaries belong to the lower quadrant.
    always_comb begin
        r = red_reg[5][34:0];
        if (r <= sqfp_pkg::HALF_PI_Q32) begin
            xf       = r;
            fold_neg = 1'b0;
        end else if (r <= sqfp_pkg::PI_Q32) begin
            xf       = sqfp_pkg::PI_Q32 - r;
            fold_neg = 1'b0;
        end else if (r <= sqfp_pkg::THREE_HALF_PI_Q32) begin
            xf       = r - sqfp_pkg::PI_Q32;
            fold_neg = 1'b1;
        end else begin
            xf       = sqfp_pkg::TWO_PI_Q32_N - r;
            fold_neg = 1'b1;
        end
    end

    // Nested polynomial, one multiply per stage.
    assign sq_prod = 62'(x_reg[6]) * 62'(x_reg[6]);
    assign prod1   = 46'(x2_reg[7]) * 46'(sqfp_pkg::DELTA_Q32);
    assign t1      = sqfp_pkg::GAMMA_Q32 - 20'(p1_reg);
    assign prod2   = 52'(x2_reg[8]) * 52'(t1);
    assign t2      = sqfp_pkg::BETA_Q32 - 26'(p2_reg);
    assign prod3   = 58'(x2_reg[9]) * 58'(t2);
    assign t3      = sqfp_pkg::ALPHA_Q32 - 30'(p3_reg);
    assign prod4   = 62'(x2_reg[10]) * 62'(t3);
    assign t4      = sqfp_pkg::ONE_Q32 - 33'(p4_reg);
    assign prod5   = 64'(x_reg[11]) * 64'(t4);

    // Saturate to +1.0, then apply the combined sign.
    assign ysat     = (y_reg > sqfp_pkg::ONE_Q30) ? sqfp_pkg::ONE_Q30 : y_reg;
    assign out_next = neg_reg[12] ? (32'd0 - ysat) : ysat;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            red_reg[0] <= {mag, 8'd0};
            neg_reg[0] <= s_tdata[31];
        end
        for (int k = 1; k <= 5; k++) begin
            if (adv[k]) begin
                red_reg[k] <= red_next[k];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        if (adv[6]) begin
            x_reg[6]   <= xf[32:2];
            neg_reg[6] <= neg_reg[5] ^ fold_neg;
        end
        for (int i = 7; i <= 11; i++) begin
            if (adv[i]) begin
                x_reg[i] <= x_reg[i-1];
            end
        end
        for (int i = 7; i <= 12; i++) begin
            if (adv[i]) begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
        if (adv[7]) begin
            x2_reg[7] <= sq_prod[61:30];
        end
        for (int i = 8; i <= 10; i++) begin
            if (adv[i]) begin
                x2_reg[i] <= x2_reg[i-1];
            end
        end
        if (adv[8]) begin
            p1_reg <= prod1[45:30];
        end
        if (adv[9]) begin
            p2_reg <= prod2[51:30];
        end
        if (adv[10]) begin
            p3_reg <= prod3[57:30];
        end
        if (adv[11]) begin
            p4_reg <= prod4[61:30];
        end
        if (adv[12]) begin
            y_reg <= prod5[63:32];
        end
        if (adv[13]) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== src/sqfp_checker.sv =====
// Port-level checks for sine_quadrant_fold_polynomial, attached by bind.
// Watches the stream handshakes and the output range; no package needed.
module sqfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Output beat drops after a reset cycle.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // An empty or draining output stage must let the input side take a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low while output can drain");

    // Result stays within [-1.0, +1.0] in Q2.30.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 32'sh4000_0000 &&
                      $signed(m_tdata) >= -32'sh4000_0000))
        else $error("sine_value out of range");

    // Hold a stalled output beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

endmodule

bind sine_quadrant_fold_polynomial sqfp_checker u_sqfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for sine_quadrant_fold_polynomial: streams Q8.24 angles in and
// checks every Q2.30 sine beat against a bit-exact fixed-point predictor.
// Depends on sqfp_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] QUARTER_TURN = 32'(sqfp_pkg::HALF_PI_Q32 >> 8);   // pi/2 in Q8.24
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 3 * sqfp_pkg::NUM_STAGES;
    localparam int unsigned MAX_REPORTS  = 40;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] sine;
    } sine_expect_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    logic [31:0]  angle_q[$];
    sine_expect_t sine_q[$];
    sine_expect_t oldest;

    int unsigned tx_idle_pct = 22;
    int unsigned rx_idle_pct = 81;
    int unsigned mismatches  = 0;
    int unsigned hold_left   = 0;
    logic        hold_req    = 1'b0;
    logic        hold_taken  = 1'b0;

    sine_quadrant_fold_polynomial uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Reduce |angle| mod 2*pi in Q.32, fold into the first quadrant, run the nested odd
    // polynomial, saturate at one and restore the sign.
    function automatic logic [31:0] sine_of_angle(input logic [31:0] angle);
        logic        ang_neg;
        logic        flip;
        logic [63:0] mag;
        logic [63:0] red;
        logic [63:0] xq;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] y;
        ang_neg = angle[31];
        mag = ang_neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        red = (mag << 8) % sqfp_pkg::TWO_PI_Q32;
        if (red <= sqfp_pkg::HALF_PI_Q32) begin
            xq = red;
            flip = 1'b0;
        end else if (red <= sqfp_pkg::PI_Q32) begin
            xq = sqfp_pkg::PI_Q32 - red;
            flip = 1'b0;
        end else if (red <= sqfp_pkg::THREE_HALF_PI_Q32) begin
            xq = red - sqfp_pkg::PI_Q32;
            flip = 1'b1;
        end else begin
            xq = sqfp_pkg::TWO_PI_Q32 - red;
            flip = 1'b1;
        end
        xq = xq >> 2;
        x2 = (xq * xq) >> 30;
        t = sqfp_pkg::GAMMA_Q32 - ((x2 * sqfp_pkg::DELTA_Q32) >> 30);
        t = sqfp_pkg::BETA_Q32 - ((x2 * t) >> 30);
        t = sqfp_pkg::ALPHA_Q32 - ((x2 * t) >> 30);
        t = sqfp_pkg::ONE_Q32 - ((x2 * t) >> 30);
        y = (xq * t) >> 32;
        if (y > sqfp_pkg::ONE_Q30)
            y = sqfp_pkg::ONE_Q30;
        if (ang_neg ^ flip)
            y = 64'd0 - y;
        return y[31:0];
    endfunction

    function automatic logic [31:0] random_angle();
        logic [31:0] a;
        case ($urandom_range(3))
            0: a = $urandom;
            1: a = $urandom_range(0, 8 * QUARTER_TURN);
            2: a = $urandom_range(0, 81) * QUARTER_TURN + $urandom_range(0, 8) - 4;
            default: a = $urandom_range(0, 32'h0001_FFFF);
        endcase
        if ($urandom_range(1))
            a = 32'd0 - a;
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count) angle_q.push_back(random_angle());
    endtask

    task automatic wait_drained();
        while (angle_q.size() != 0 || s_tvalid || sine_q.size() != 0 || hold_left != 0)
            @(negedge aclk);
    endtask

    // Driver: record the expected sine when a beat is taken, then offer the next angle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                sine_q.push_back('{angle: s_tdata, sine: sine_of_angle(s_tdata)});
            if (!s_tvalid || s_tready) begin
                if (angle_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tdata  <= angle_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long back-pressure window, armed once by the stimulus.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: every result beat must match the oldest outstanding angle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sine_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat sine=%h", m_tdata));
            end else begin
                oldest = sine_q.pop_front();
                if (m_tdata !== oldest.sine)
                    report_mismatch($sformatf("angle=%h sine=%h, want %h",
                                              oldest.angle, m_tdata, oldest.sine));
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Extremes, quadrant boundaries on both sides, negative angles, overshoot at pi/2.
        angle_q.push_back(32'h0000_0000);
        angle_q.push_back(32'h0000_0001);
        angle_q.push_back(32'hFFFF_FFFF);
        angle_q.push_back(32'h7FFF_FFFF);
        angle_q.push_back(32'h8000_0000);
        angle_q.push_back(32'h0100_0000);
        angle_q.push_back(32'h5555_5555);
        angle_q.push_back(32'hAAAA_AAAA);
        angle_q.push_back(QUARTER_TURN - 1);
        angle_q.push_back(QUARTER_TURN);
        angle_q.push_back(QUARTER_TURN + 1);
        angle_q.push_back(2 * QUARTER_TURN);
        angle_q.push_back(2 * QUARTER_TURN + 1);
        angle_q.push_back(3 * QUARTER_TURN);
        angle_q.push_back(3 * QUARTER_TURN + 1);
        angle_q.push_back(4 * QUARTER_TURN - 1);
        angle_q.push_back(4 * QUARTER_TURN);
        angle_q.push_back(5 * QUARTER_TURN);
        angle_q.push_back(32'd0 - QUARTER_TURN);
        angle_q.push_back(32'd0 - 2 * QUARTER_TURN);
        angle_q.push_back(32'd0 - 3 * QUARTER_TURN);
        angle_q.push_back(32'd0 - 81 * QUARTER_TURN);
        queue_random(430);
        wait_drained();

        tx_idle_pct = 81;
        rx_idle_pct = 22;
        queue_random(450);
        wait_drained();

        // Full rate, with one long receiver stall to back the pipeline up.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(450);
        hold_req = 1'b1;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/sqfp_pkg.sv
src/sine_quadrant_fold_polynomial.sv
src/sqfp_checker.sv
dv/testbench.sv
